>>> design/keyboard_report_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// Keyboard report tracker assertion macros
// Shared property wrappers used by the tracker's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_REPORT_TRACKER_CORE_MACROS_SVH
`define KEYBOARD_REPORT_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KBRT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define KBRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/kbrt_pkg.sv
// ----------------------------------------------------------------------------
// kbrt_pkg
// Widths, usage codes and helper functions for the keyboard report tracker.
// ----------------------------------------------------------------------------
package kbrt_pkg;

  localparam int KEY_SLOTS_DEF = 6;
  localparam int REPORT_SLOTS  = 6;
  localparam int PAD_KEYS      = 12;
  localparam int CODE_W        = 8;
  localparam int MOD_W         = 7;

  // action field codes
  localparam logic ACT_PRESS   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // usage codes
  localparam logic [CODE_W-1:0] CODE_NONE   = 8'h00;
  localparam logic [CODE_W-1:0] CODE_LCTRL  = 8'he0;
  localparam logic [CODE_W-1:0] CODE_LSHIFT = 8'he1;
  localparam logic [CODE_W-1:0] CODE_LALT   = 8'he2;
  localparam logic [CODE_W-1:0] CODE_RCTRL  = 8'he4;
  localparam logic [CODE_W-1:0] CODE_RSHIFT = 8'he5;
  localparam logic [CODE_W-1:0] CODE_RALT   = 8'he6;

  // modifier byte bit positions
  localparam int MOD_BIT_LCTRL = 0;
  localparam int MOD_BIT_RCTRL = 4;

  // gamepad word bits also driven by the Ctrl keys
  localparam int PAD_BIT_LCTRL = 4;
  localparam int PAD_BIT_RCTRL = 5;

  // gamepad key i is held when this code sits in a slot
  localparam logic [CODE_W-1:0] PAD_CODES [PAD_KEYS] = '{
    8'h07, 8'h09, 8'h08, 8'h15, 8'he0, 8'he4,
    8'h2c, 8'h28, 8'h52, 8'h51, 8'h50, 8'h4f
  };

  // modifier bit for a usage code, zero for ordinary keys
  function automatic logic [MOD_W-1:0] mod_mask(input logic [CODE_W-1:0] code);
    logic [MOD_W-1:0] m;
    case (code)
      CODE_LCTRL:  m = 7'h01;
      CODE_LSHIFT: m = 7'h02;
      CODE_LALT:   m = 7'h04;
      CODE_RCTRL:  m = 7'h10;
      CODE_RSHIFT: m = 7'h20;
      CODE_RALT:   m = 7'h40;
      default:     m = '0;
    endcase
    return m;
  endfunction

endpackage

>>> design/kbrt_in_if.sv
// ----------------------------------------------------------------------------
// kbrt_in_if
// Key event channel: valid/ready with action and usage code.
// ----------------------------------------------------------------------------
interface kbrt_in_if;
  import kbrt_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [CODE_W-1:0] usage_code;

  modport source (output valid, action, usage_code, input ready);
  modport sink   (input valid, action, usage_code, output ready);
endinterface

>>> design/kbrt_out_if.sv
// ----------------------------------------------------------------------------
// kbrt_out_if
// Report channel: valid/ready with modifier byte, six slots and pad word.
// ----------------------------------------------------------------------------
interface kbrt_out_if;
  import kbrt_pkg::*;

  logic              valid;
  logic              ready;
  logic [MOD_W-1:0]  modifier_bits;
  logic [CODE_W-1:0] slot_zero;
  logic [CODE_W-1:0] slot_one;
  logic [CODE_W-1:0] slot_two;
  logic [CODE_W-1:0] slot_three;
  logic [CODE_W-1:0] slot_four;
  logic [CODE_W-1:0] slot_five;
  logic [PAD_KEYS-1:0] pad_buttons;

  modport source (output valid, modifier_bits, slot_zero, slot_one, slot_two,
                  slot_three, slot_four, slot_five, pad_buttons, input ready);
  modport sink   (input valid, modifier_bits, slot_zero, slot_one, slot_two,
                  slot_three, slot_four, slot_five, pad_buttons, output ready);
endinterface

>>> design/kbrt_update.sv
// ----------------------------------------------------------------------------
// kbrt_update
// Next modifier byte and slot contents for one key event.
// ----------------------------------------------------------------------------
module kbrt_update #(
  parameter int KEY_SLOTS = kbrt_pkg::KEY_SLOTS_DEF
) (
  input  logic                        action,
  input  logic [kbrt_pkg::CODE_W-1:0] usage_code,
  input  logic [kbrt_pkg::MOD_W-1:0]  mod_cur,
  input  logic [kbrt_pkg::CODE_W-1:0] slots_cur [KEY_SLOTS],
  output logic [kbrt_pkg::MOD_W-1:0]  mod_next,
  output logic [kbrt_pkg::CODE_W-1:0] slots_next [KEY_SLOTS]
);
  import kbrt_pkg::*;

  logic [MOD_W-1:0]  mask;
  logic              release_ev;
  logic [CODE_W-1:0] want;
  logic [CODE_W-1:0] put;
  logic              found;

  assign mask       = mod_mask(usage_code);
  assign release_ev = (action == ACT_RELEASE);
  // press looks for an empty slot, release looks for the key itself
  assign want       = release_ev ? usage_code : CODE_NONE;
  assign put        = release_ev ? CODE_NONE : usage_code;

  // modifier keys touch the byte, other nonzero codes touch the first match
  always_comb begin
    mod_next   = mod_cur;
    slots_next = slots_cur;
    found      = 1'b0;
    if (mask != '0) begin
      mod_next = release_ev ? (mod_cur & ~mask) : (mod_cur | mask);
    end else if (usage_code != CODE_NONE) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (!found && slots_cur[i] == want) begin
          slots_next[i] = put;
          found         = 1'b1;
        end
      end
    end
  end

endmodule

>>> design/kbrt_pad.sv
// ----------------------------------------------------------------------------
// kbrt_pad
// Gamepad word from the held keys and the Ctrl modifiers.
// ----------------------------------------------------------------------------
module kbrt_pad #(
  parameter int KEY_SLOTS = kbrt_pkg::KEY_SLOTS_DEF
) (
  input  logic [kbrt_pkg::MOD_W-1:0]    mods,
  input  logic [kbrt_pkg::CODE_W-1:0]   slots [KEY_SLOTS],
  output logic [kbrt_pkg::PAD_KEYS-1:0] pad
);
  import kbrt_pkg::*;

  logic [PAD_KEYS-1:0] hit;

  // one compare per pad key per slot, OR-reduced
  always_comb begin
    hit = '0;
    for (int k = 0; k < PAD_KEYS; k++) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (slots[i] == PAD_CODES[k]) begin
          hit[k] = 1'b1;
        end
      end
    end
  end

  // Ctrl keys double as shoulder buttons
  always_comb begin
    pad                = hit;
    pad[PAD_BIT_LCTRL] = hit[PAD_BIT_LCTRL] | mods[MOD_BIT_LCTRL];
    pad[PAD_BIT_RCTRL] = hit[PAD_BIT_RCTRL] | mods[MOD_BIT_RCTRL];
  end

endmodule

>>> design/keyboard_report_tracker_core.sv
// ----------------------------------------------------------------------------
// keyboard_report_tracker_core
// Boot-keyboard report tracker: modifier byte, key slots and gamepad word.
// ----------------------------------------------------------------------------
// Usage:
//   key_in carries one key event per beat (action: 0 press, 1 release, and
//   a USB usage code). report_out carries one report per event: modifier
//   byte, the first six key slots and a 12-bit gamepad word, all taken
//   after the event has been applied.
//   An event taken by key_in lands in the input register, and its report is
//   then registered in the output register.
//   Throughput is one event per cycle while report_out does not stall; the
//   state update, six slot compares, priority pick and pad compares sit in
//   the logic between the input register and the output register.
//   When report_out stalls, the pending report holds and one more event
//   waits in the input register; key_in.ready drops only then.
//   Synchronous reset empties both registers, clears the modifier byte and
//   sets every key slot to empty (zero). No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "keyboard_report_tracker_core_macros.svh"

module keyboard_report_tracker_core #(
  parameter int KEY_SLOTS = kbrt_pkg::KEY_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  kbrt_in_if.sink    key_in,
  kbrt_out_if.source report_out
);
  import kbrt_pkg::*;

  // input register
  logic              s1_valid;
  logic              s1_action;
  logic [CODE_W-1:0] s1_code;
  logic              s1_advance;

  // tracked state
  logic [MOD_W-1:0]  mod_state;
  logic [CODE_W-1:0] slots [KEY_SLOTS];
  logic [MOD_W-1:0]  mod_next;
  logic [CODE_W-1:0] slots_next [KEY_SLOTS];
  logic [PAD_KEYS-1:0] pad_next;
  logic [CODE_W-1:0] report_next [REPORT_SLOTS];

  // output register
  logic              out_valid;
  logic [MOD_W-1:0]  out_mod;
  logic [CODE_W-1:0] out_slot [REPORT_SLOTS];
  logic [PAD_KEYS-1:0] out_pad;

  // handshake
  assign s1_advance   = s1_valid && (!out_valid || report_out.ready);
  assign key_in.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_in.ready) begin
      s1_valid <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.valid && key_in.ready) begin
      s1_action <= key_in.action;
      s1_code   <= key_in.usage_code;
    end
  end

  kbrt_update #(.KEY_SLOTS(KEY_SLOTS)) u_update (
    .action     (s1_action),
    .usage_code (s1_code),
    .mod_cur    (mod_state),
    .slots_cur  (slots),
    .mod_next   (mod_next),
    .slots_next (slots_next)
  );

  kbrt_pad #(.KEY_SLOTS(KEY_SLOTS)) u_pad (
    .mods  (mod_next),
    .slots (slots_next),
    .pad   (pad_next)
  );

  // report shows the first six slots, missing ones read empty
  for (genvar r = 0; r < REPORT_SLOTS; r++) begin : g_report
    if (r < KEY_SLOTS) begin : g_have
      assign report_next[r] = slots_next[r];
    end else begin : g_none
      assign report_next[r] = CODE_NONE;
    end
  end

  // state commits when the event moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mod_state <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        slots[i] <= CODE_NONE;
      end
    end else if (s1_advance) begin
      mod_state <= mod_next;
      slots     <= slots_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (report_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_mod  <= mod_next;
      out_slot <= report_next;
      out_pad  <= pad_next;
    end
  end

  assign report_out.valid         = out_valid;
  assign report_out.modifier_bits = out_mod;
  assign report_out.slot_zero     = out_slot[0];
  assign report_out.slot_one      = out_slot[1];
  assign report_out.slot_two      = out_slot[2];
  assign report_out.slot_three    = out_slot[3];
  assign report_out.slot_four     = out_slot[4];
  assign report_out.slot_five     = out_slot[5];
  assign report_out.pad_buttons   = out_pad;

  // checks
  `KBRT_ASSERT_NEXT(a_advance_fills, clk, rst, s1_advance, out_valid,
    "event left input register but no report appeared")
  `KBRT_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, key_in.ready,
    "input stalled while output register empty")
  `KBRT_ASSERT_NOW(a_lctrl_pad, clk, rst,
    out_valid && out_mod[MOD_BIT_LCTRL], out_pad[PAD_BIT_LCTRL],
    "LCtrl held but shoulder bit clear")
  `KBRT_ASSERT_NOW(a_rctrl_pad, clk, rst,
    out_valid && out_mod[MOD_BIT_RCTRL], out_pad[PAD_BIT_RCTRL],
    "RCtrl held but shoulder bit clear")

endmodule

>>> dv/tb_keyboard_report_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keyboard_report_tracker_core
// Self-checking bench for the keyboard report tracker. A short table of key
// events walks the modifier keys, the slot-full, duplicate and stray-release
// cases, then a long random run of presses and releases follows, biased
// toward keys that are held. Every report is compared field by field with a
// table row or a local model of the modifier byte, key slots and pad word.
// Both channels see random idle bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_keyboard_report_tracker_core;
  import kbrt_pkg::*;

  localparam int NUM_SLOTS     = KEY_SLOTS_DEF;
  localparam int RANDOM_EVENTS = 750;
  localparam int TAIL_EVENTS   = 120;
  localparam int DIRECTED_ROWS = 25;

  // GUI keys are not modifiers here; they take a slot like any other key
  localparam logic [CODE_W-1:0] CODE_LGUI = 8'he3;
  localparam logic [CODE_W-1:0] CODE_RGUI = 8'he7;

  typedef struct packed {
    logic [MOD_W-1:0]                  mods;
    logic [REPORT_SLOTS-1:0][CODE_W-1:0] slots;
    logic [PAD_KEYS-1:0]               pad;
  } report_t;

  typedef struct packed {
    logic              act;
    logic [CODE_W-1:0] code;
    logic              literal;
    report_t           want;
  } key_step_t;

  logic clk = 1'b0;
  logic rst;

  kbrt_in_if  key_if ();
  kbrt_out_if rpt_if ();

  keyboard_report_tracker_core u_top (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_if),
    .report_out (rpt_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state
  logic [MOD_W-1:0]  held_mods;
  logic [CODE_W-1:0] held_slots [NUM_SLOTS];

  report_t pending_reports [$];
  int      mismatch_count = 0;
  logic    steady_tail = 1'b0;
  int      gap_rate = 20;

  // Directed table: literal rows carry an expectation read straight off the
  // spec, the rest are checked against the model
  key_step_t directed_steps [DIRECTED_ROWS] = '{
    '{ACT_PRESS,   CODE_NONE,   1'b1, '{7'h00, '0, 12'h000}},
    '{ACT_RELEASE, CODE_NONE,   1'b1, '{7'h00, '0, 12'h000}},
    '{ACT_PRESS,   CODE_LCTRL,  1'b1, '{7'h01, '0, 12'h010}},
    '{ACT_PRESS,   CODE_RCTRL,  1'b1, '{7'h11, '0, 12'h030}},
    '{ACT_PRESS,   8'h07,       1'b1, '{7'h11, 48'h07, 12'h031}},
    '{ACT_PRESS,   CODE_LSHIFT, 1'b0, '0},
    '{ACT_PRESS,   CODE_LALT,   1'b0, '0},
    '{ACT_PRESS,   CODE_RSHIFT, 1'b0, '0},
    '{ACT_PRESS,   CODE_RALT,   1'b0, '0},
    '{ACT_PRESS,   8'h07,       1'b0, '0},   // same key again takes a second slot
    '{ACT_PRESS,   8'hff,       1'b0, '0},
    '{ACT_PRESS,   CODE_LGUI,   1'b0, '0},
    '{ACT_PRESS,   CODE_RGUI,   1'b0, '0},
    '{ACT_PRESS,   8'h01,       1'b0, '0},   // last free slot
    '{ACT_PRESS,   8'h28,       1'b0, '0},   // all full: dropped
    '{ACT_RELEASE, 8'h55,       1'b0, '0},   // not held
    '{ACT_RELEASE, 8'h07,       1'b0, '0},   // clears first copy only
    '{ACT_PRESS,   8'h52,       1'b0, '0},
    '{ACT_RELEASE, CODE_LSHIFT, 1'b0, '0},
    '{ACT_RELEASE, CODE_RALT,   1'b0, '0},
    '{ACT_RELEASE, CODE_RALT,   1'b0, '0},   // modifier already up
    '{ACT_RELEASE, CODE_LCTRL,  1'b0, '0},
    '{ACT_RELEASE, CODE_RCTRL,  1'b0, '0},
    '{ACT_RELEASE, 8'h07,       1'b0, '0},
    '{ACT_PRESS,   8'h2c,       1'b0, '0}
  };

  // Apply one key event to the model and return the report it produces
  function automatic report_t apply_key_event(input logic act, input logic [CODE_W-1:0] code);
    report_t r;
    logic    done;
    r    = '0;
    done = 1'b0;
    // Ctrl/Shift/Alt sit at E0-E2 and E4-E6; the low three bits give the bit
    if (code[7:3] == 5'b11100 && code[1:0] != 2'b11) begin
      held_mods[code[2:0]] = (act == ACT_PRESS);
    end else if (code != CODE_NONE) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!done && act == ACT_PRESS && held_slots[i] == CODE_NONE) begin
          held_slots[i] = code;
          done = 1'b1;
        end else if (!done && act == ACT_RELEASE && held_slots[i] == code) begin
          held_slots[i] = CODE_NONE;
          done = 1'b1;
        end
      end
    end
    r.mods = held_mods;
    for (int i = 0; i < REPORT_SLOTS; i++)
      r.slots[i] = (i < NUM_SLOTS) ? held_slots[i] : CODE_NONE;
    for (int k = 0; k < PAD_KEYS; k++)
      for (int i = 0; i < NUM_SLOTS; i++)
        if (held_slots[i] == PAD_CODES[k]) r.pad[k] = 1'b1;
    if (held_mods[MOD_BIT_LCTRL]) r.pad[PAD_BIT_LCTRL] = 1'b1;
    if (held_mods[MOD_BIT_RCTRL]) r.pad[PAD_BIT_RCTRL] = 1'b1;
    return r;
  endfunction

  // Offer one event, with an optional idle burst first; valid stays high
  // after the beat so back-to-back events need no extra edge
  task automatic send_key(input logic act, input logic [CODE_W-1:0] code);
    if (!steady_tail && $urandom_range(0, 99) < gap_rate) begin
      key_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    key_if.valid      <= 1'b1;
    key_if.action     <= act;
    key_if.usage_code <= code;
    do @(posedge clk); while (!key_if.ready);
  endtask

  // Report channel back-pressure: random stall bursts, with the stall rate
  // redrawn whenever stall_epoch wraps so some stretches run clean
  int          stall_left = 0;
  int          stall_rate = 0;
  logic [5:0]  stall_epoch = '0;

  always @(posedge clk) begin
    stall_epoch <= stall_epoch + 1'b1;
    if (stall_epoch == '0) begin
      case ($urandom_range(0, 2))
        0:       stall_rate <= 0;
        1:       stall_rate <= 15;
        default: stall_rate <= 45;
      endcase
    end
    if (stall_left != 0) begin
      rpt_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!steady_tail && $urandom_range(0, 99) < stall_rate) begin
      rpt_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      rpt_if.ready <= 1'b1;
    end
  end

  // Report checker
  report_t got_report;
  report_t want_report;

  always @(posedge clk) begin
    if (!rst && rpt_if.valid && rpt_if.ready) begin
      got_report.mods     = rpt_if.modifier_bits;
      got_report.slots[0] = rpt_if.slot_zero;
      got_report.slots[1] = rpt_if.slot_one;
      got_report.slots[2] = rpt_if.slot_two;
      got_report.slots[3] = rpt_if.slot_three;
      got_report.slots[4] = rpt_if.slot_four;
      got_report.slots[5] = rpt_if.slot_five;
      got_report.pad      = rpt_if.pad_buttons;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report beat, actual %h", $time, got_report);
        mismatch_count++;
      end else begin
        want_report = pending_reports.pop_front();
        if (got_report.mods !== want_report.mods) begin
          $display("%0t: modifier_bits expected %h actual %h",
                   $time, want_report.mods, got_report.mods);
          mismatch_count++;
        end
        for (int i = 0; i < REPORT_SLOTS; i++) begin
          if (got_report.slots[i] !== want_report.slots[i]) begin
            $display("%0t: slot %0d expected %h actual %h",
                     $time, i, want_report.slots[i], got_report.slots[i]);
            mismatch_count++;
          end
        end
        if (got_report.pad !== want_report.pad) begin
          $display("%0t: pad_buttons expected %h actual %h",
                   $time, want_report.pad, got_report.pad);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus
  report_t              model_report;
  logic                 rand_act;
  logic [CODE_W-1:0]    rand_code;
  int                   pick;
  int                   slot_pick;

  initial begin
    rst                 <= 1'b1;
    key_if.valid        <= 1'b0;
    key_if.action       <= ACT_PRESS;
    key_if.usage_code   <= CODE_NONE;
    held_mods = '0;
    foreach (held_slots[i]) held_slots[i] = CODE_NONE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_steps[n]) begin
      send_key(directed_steps[n].act, directed_steps[n].code);
      model_report = apply_key_event(directed_steps[n].act, directed_steps[n].code);
      if (directed_steps[n].literal)
        pending_reports.push_back(directed_steps[n].want);
      else
        pending_reports.push_back(model_report);
    end

    // Random events, mostly presses of pad/modifier keys and releases of
    // keys that are actually held, with some raw noise mixed in
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 50 == 0) gap_rate = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 45);
      if (n == RANDOM_EVENTS - TAIL_EVENTS) steady_tail = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        rand_act = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
          0:       rand_code = CODE_LCTRL;
          1:       rand_code = CODE_LSHIFT;
          2:       rand_code = CODE_LALT;
          3:       rand_code = CODE_RCTRL;
          4:       rand_code = CODE_RSHIFT;
          default: rand_code = CODE_RALT;
        endcase
      end else if (pick < 35) begin
        rand_act  = ACT_PRESS;
        rand_code = PAD_CODES[$urandom_range(0, PAD_KEYS - 1)];
      end else if (pick < 68) begin
        rand_act  = ACT_RELEASE;
        slot_pick = $urandom_range(0, NUM_SLOTS - 1);
        rand_code = held_slots[slot_pick];
        if (rand_code == CODE_NONE) rand_code = CODE_W'($urandom_range(0, 255));
      end else if (pick < 80) begin
        rand_act  = 1'($urandom_range(0, 1));
        rand_code = CODE_W'($urandom_range(0, 255));
      end else if (pick < 85) begin
        rand_act = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0:       rand_code = CODE_NONE;
          1:       rand_code = CODE_LGUI;
          2:       rand_code = CODE_RGUI;
          default: rand_code = 8'hff;
        endcase
      end else begin
        rand_act  = ACT_PRESS;
        rand_code = CODE_W'($urandom_range(1, 255));
      end
      send_key(rand_act, rand_code);
      pending_reports.push_back(apply_key_event(rand_act, rand_code));
    end
    key_if.valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("keyboard_report_tracker_core regression: pass");
    end else begin
      $display("keyboard_report_tracker_core regression: fail");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2ms;
    $display("%0t: timeout, %0d reports outstanding", $time, pending_reports.size());
    $display("keyboard_report_tracker_core regression: fail");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/kbrt_pkg.sv
design/kbrt_in_if.sv
design/kbrt_out_if.sv
design/kbrt_update.sv
design/kbrt_pad.sv
design/keyboard_report_tracker_core.sv
dv/tb_keyboard_report_tracker_core.sv
